[rtl/core/utf8s_pkg.sv]
// shared types, constants and helpers of the utf8 sanitizer
package utf8s_pkg;

  localparam int NUM_UNITS = 4;
  localparam int NUM_HELD  = 3;
  localparam int Q_DEPTH   = 2;

  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam logic [7:0] REP_B0 = 8'hEF;
  localparam logic [7:0] REP_B1 = 8'hBF;
  localparam logic [7:0] REP_B2 = 8'hBD;

  localparam logic [1:0] REP_SUB_LAST = 2'd2;

  // one output unit: a literal byte or a three byte replacement
  typedef struct packed {
    logic       rep;
    logic [7:0] lit;
  } unit_t;

  // one queued command: the units caused by one input byte
  typedef struct packed {
    unit_t [NUM_UNITS-1:0] units;
    logic  [2:0]           n;
    logic                  eoi;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] rep_byte(input logic [1:0] sub);
    logic [7:0] r;
    unique case (sub)
      2'd0:    r = REP_B0;
      2'd1:    r = REP_B1;
      default: r = REP_B2;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/utf8s_front.sv]
// front end: accepts bytes, tracks the open sequence and builds output commands
module utf8s_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  end_of_input,
  input  utf8s_pkg::q_status_t  q_status,
  output logic                  push,
  output utf8s_pkg::cmd_t       cmd
);

  logic [7:0] held      [utf8s_pkg::NUM_HELD];
  logic [7:0] held_next [utf8s_pkg::NUM_HELD];
  logic [1:0] held_count, held_count_next;
  logic [2:0] needed_length, needed_length_next;

  logic       accept;
  logic       is_cont;
  logic       is_ascii;
  logic [2:0] lead_len;
  logic       seq_open;
  logic [1:0] pre;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign push     = accept && (cmd.n != 3'd0);

  always_comb begin
    is_cont  = (in_byte & utf8s_pkg::CONT_MASK) == utf8s_pkg::CONT_TAG;
    is_ascii = in_byte <= utf8s_pkg::ASCII_MAX;
    lead_len = 3'd0;
    if (in_byte >= utf8s_pkg::LEAD2_LO && in_byte <= utf8s_pkg::LEAD2_HI) begin
      lead_len = 3'd2;
    end else if (in_byte >= utf8s_pkg::LEAD3_LO && in_byte <= utf8s_pkg::LEAD3_HI) begin
      lead_len = 3'd3;
    end else if (in_byte >= utf8s_pkg::LEAD4_LO && in_byte <= utf8s_pkg::LEAD4_HI) begin
      lead_len = 3'd4;
    end
    seq_open = needed_length != 3'd0;
    pre      = seq_open ? held_count : 2'd0;
  end

  always_comb begin
    cmd                = '0;
    cmd.eoi            = end_of_input;
    held_next          = held;
    held_count_next    = 2'd0;
    needed_length_next = 3'd0;
    if (seq_open && is_cont) begin
      if ({1'b0, held_count} + 3'd1 >= needed_length) begin
        // sequence complete
        for (int k = 0; k < utf8s_pkg::NUM_HELD; k++) begin
          if (2'(k) < held_count) begin
            cmd.units[k].lit = held[k];
          end
          if (2'(k) == held_count) begin
            cmd.units[k].lit = in_byte;
          end
        end
        if (held_count == 2'd3) begin
          cmd.units[utf8s_pkg::NUM_UNITS-1].lit = in_byte;
        end
        cmd.n = {1'b0, held_count} + 3'd1;
      end else if (end_of_input) begin
        // cut short at end
        for (int k = 0; k < utf8s_pkg::NUM_HELD; k++) begin
          if (2'(k) <= held_count) begin
            cmd.units[k].rep = 1'b1;
          end
        end
        cmd.n = {1'b0, held_count} + 3'd1;
      end else begin
        for (int k = 0; k < utf8s_pkg::NUM_HELD; k++) begin
          if (2'(k) == held_count) begin
            held_next[k] = in_byte;
          end
        end
        held_count_next    = held_count + 2'd1;
        needed_length_next = needed_length;
      end
    end else begin
      // no continuation byte: each held byte of a broken sequence turns into a replacement
      for (int k = 0; k < utf8s_pkg::NUM_HELD; k++) begin
        if (2'(k) < pre) begin
          cmd.units[k].rep = 1'b1;
        end
      end
      if (is_ascii) begin
        cmd.units[pre].lit = in_byte;
        cmd.n              = {1'b0, pre} + 3'd1;
      end else if (lead_len == 3'd0 || end_of_input) begin
        cmd.units[pre].rep = 1'b1;
        cmd.n              = {1'b0, pre} + 3'd1;
      end else begin
        cmd.n              = {1'b0, pre};
        held_next[0]       = in_byte;
        held_count_next    = 2'd1;
        needed_length_next = lead_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= 2'd0;
      needed_length <= 3'd0;
    end else if (accept) begin
      held_count    <= held_count_next;
      needed_length <= needed_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

endmodule

[rtl/core/utf8s_queue.sv]
// two entry command queue between front and back
module utf8s_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  utf8s_pkg::cmd_t      push_cmd,
  input  logic                 pop,
  output utf8s_pkg::cmd_t      head,
  output utf8s_pkg::q_status_t status
);

  utf8s_pkg::cmd_t mem [utf8s_pkg::Q_DEPTH];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign head         = mem[rd_ptr];
  assign status.full  = count == 2'(utf8s_pkg::Q_DEPTH);
  assign status.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/core/utf8s_back.sv]
// back end: walks the head command and emits one byte per cycle while the queue is not empty and out_stall is low
module utf8s_back (
  input  logic                 clk,
  input  logic                 rst,
  input  utf8s_pkg::cmd_t      head,
  input  utf8s_pkg::q_status_t q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 run_last,
  output logic                 stream_end
);

  logic             load;
  logic             go;
  logic [1:0]       uidx;
  logic [1:0]       sub;
  utf8s_pkg::unit_t cur;
  logic [7:0]       cur_byte;
  logic             unit_done;
  logic             cmd_done;

  always_comb begin
    load      = !out_valid || !out_stall;
    go        = load && !q_status.empty;
    cur       = head.units[uidx];
    cur_byte  = cur.rep ? utf8s_pkg::rep_byte(sub) : cur.lit;
    unit_done = !cur.rep || sub == utf8s_pkg::REP_SUB_LAST;
    cmd_done  = unit_done && ({1'b0, uidx} == head.n - 3'd1);
    pop       = go && cmd_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      uidx      <= 2'd0;
      sub       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= !q_status.empty;
      end
      if (go) begin
        if (unit_done) begin
          sub  <= 2'd0;
          uidx <= cmd_done ? 2'd0 : uidx + 2'd1;
        end else begin
          sub <= sub + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_byte   <= cur_byte;
      run_last   <= cmd_done;
      stream_end <= cmd_done && head.eoi;
    end
  end

endmodule

[rtl/core/utf8_sanitizer.sv]
// utf8 sanitizer top level: front end, command queue and back end
// a result byte passes through a queue entry and then the single output byte register
// throughput: one byte per cycle while out_stall is low, set by the single output byte register;
// an input byte causing k results (k up to 12) holds the back end for them; the two entry queue absorbs bursts
// reset: synchronous, clears the open sequence, the queue and the output valid
module utf8_sanitizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       stream_end
);

  utf8s_pkg::cmd_t      cmd;
  utf8s_pkg::cmd_t      head;
  utf8s_pkg::q_status_t q_status;
  logic                 push;
  logic                 pop;

  utf8s_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .q_status     (q_status),
    .push         (push),
    .cmd          (cmd)
  );

  utf8s_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  utf8s_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .stream_end (stream_end)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> run_last)
    else $error("stream end without run last");

  a_pushed_cmd_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (cmd.n != 3'd0 && cmd.n <= 3'(utf8s_pkg::NUM_UNITS)))
    else $error("bad command unit count");

endmodule
